FILE: sv/rv32i_decoded_instruction_execute_macros.svh
// Assertion macros for the RV32I decoded-instruction execute block.
// Included by the top level; needs no package.
`ifndef RV32I_DECODED_INSTRUCTION_EXECUTE_MACROS_SVH
`define RV32I_DECODED_INSTRUCTION_EXECUTE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define RV32IE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define RV32IE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RV32IE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define RV32IE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: sv/rv32ie_pkg.sv
// Shared types, codes and helpers of the RV32I decoded-instruction execute block.
// No dependencies.
`default_nettype none

package rv32ie_pkg;

   // memory size in bytes; a power of two, the pc wraps by masking
   localparam longint unsigned MemSizeBytes = 64'd65536;
   localparam logic [15:0]     PcMask       = 16'((MemSizeBytes - 64'd1) & 64'hFFFF);
   localparam int              RegCount     = 32;
   localparam int              UpperShift   = 12;
   localparam logic [31:0]     PcStep       = 32'd4;

   typedef enum logic [5:0] {
      OP_ADD   = 6'd0,  OP_AND   = 6'd1,  OP_OR    = 6'd2,  OP_XOR   = 6'd3,
      OP_SUB   = 6'd4,  OP_SLL   = 6'd5,  OP_SRL   = 6'd6,  OP_SRA   = 6'd7,
      OP_SLT   = 6'd8,  OP_SLTU  = 6'd9,  OP_ADDI  = 6'd10, OP_ANDI  = 6'd11,
      OP_ORI   = 6'd12, OP_XORI  = 6'd13, OP_SLLI  = 6'd14, OP_SRLI  = 6'd15,
      OP_SRAI  = 6'd16, OP_SLTI  = 6'd17, OP_SLTIU = 6'd18, OP_LB    = 6'd19,
      OP_LBU   = 6'd20, OP_LH    = 6'd21, OP_LHU   = 6'd22, OP_LW    = 6'd23,
      OP_SB    = 6'd24, OP_SH    = 6'd25, OP_SW    = 6'd26, OP_BEQ   = 6'd27,
      OP_BNE   = 6'd28, OP_BGE   = 6'd29, OP_BGEU  = 6'd30, OP_BLT   = 6'd31,
      OP_BLTU  = 6'd32, OP_JAL   = 6'd33, OP_JALR  = 6'd34, OP_AUIPC = 6'd35,
      OP_LUI   = 6'd36, OP_HCF   = 6'd37, OP_UNIMP = 6'd38
   } op_type;

   typedef enum logic [1:0] {
      MODE_INSTR = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_STORE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      WAIT_NONE  = 2'd0,
      WAIT_LOAD  = 2'd1,
      WAIT_STORE = 2'd2
   } wait_type;

   typedef enum logic [1:0] {
      MEM_NONE  = 2'd0,
      MEM_READ  = 2'd1,
      MEM_WRITE = 2'd2
   } mem_req_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  opcode;
      logic [4:0]  reg_first;
      logic [4:0]  reg_second;
      logic [4:0]  reg_third;
      logic [31:0] imm;
      logic [31:0] load_data;
   } item_type;

   typedef struct packed {
      logic [15:0] pc;
      logic [4:0]  pending_dest;
      wait_type    waiting_kind;
      logic        halt;
   } state_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic [1:0]  mem_request;
      logic [2:0]  mem_access_kind;
      logic [31:0] mem_address;
      logic [31:0] mem_write_data;
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        halted;
      logic        status;
   } rsp_type;

   // second read port: third operand for register-register forms, else first
   function automatic logic [4:0] port_b_addr(logic [5:0] opcode, logic [4:0] first,
                                              logic [4:0] third);
      return (opcode inside {[OP_ADD:OP_SLTU]}) ? third : first;
   endfunction

   function automatic logic [15:0] wrap_pc(logic [31:0] v);
      return v[15:0] & PcMask;
   endfunction

endpackage

`default_nettype wire

FILE: sv/rv32ie_regfile.sv
// 32 x 32 register file: two registered read ports, one write port.
// Valid bits give the all-zero reset value. Uses rv32ie_pkg.
`default_nettype none

module rv32ie_regfile (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rd_en,
   input  wire logic [4:0]  rd_addr_a,
   input  wire logic [4:0]  rd_addr_b,
   output logic      [31:0] rd_data_a,
   output logic      [31:0] rd_data_b,
   input  wire logic        wr_en,
   input  wire logic [4:0]  wr_addr,
   input  wire logic [31:0] wr_data
);

   logic [31:0]                     mem_ff [0:rv32ie_pkg::RegCount-1];
   logic [rv32ie_pkg::RegCount-1:0] valid_ff;
   logic [31:0]                     data_a_ff;
   logic [31:0]                     data_b_ff;
   logic                            ok_a_ff;
   logic                            ok_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // read before write at the same address: old data, bypassed upstream
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= mem_ff[rd_addr_a];
         data_b_ff <= mem_ff[rd_addr_b];
         ok_a_ff   <= valid_ff[rd_addr_a];
         ok_b_ff   <= valid_ff[rd_addr_b];
      end
   end

   assign rd_data_a = ok_a_ff ? data_a_ff : '0;
   assign rd_data_b = ok_b_ff ? data_b_ff : '0;

endmodule

`default_nettype wire

FILE: sv/rv32ie_exec.sv
// Execute logic for one beat: ALU, branches, jumps, memory requests, completions.
// Combinational; uses rv32ie_pkg types and helpers.
`default_nettype none

module rv32ie_exec (
   input  wire rv32ie_pkg::item_type  item,
   input  wire logic [31:0]           src_b,
   input  wire logic [31:0]           src_x,
   input  wire rv32ie_pkg::state_type state,
   output rv32ie_pkg::rsp_type        rsp,
   output rv32ie_pkg::state_type      state_next
);

   logic [31:0] pc32;
   logic [31:0] npc32;
   logic [31:0] wv;
   logic [4:0]  widx;
   logic        wr;
   logic        wr_eff;
   logic        advance;

   assign pc32 = {16'd0, state.pc};

   always_comb begin
      state_next          = state;
      rsp                 = '0;
      npc32               = pc32 + rv32ie_pkg::PcStep;
      wv                  = '0;
      widx                = item.reg_first;
      wr                  = 1'b0;
      advance             = 1'b1;

      if (state.halt) begin
         rsp.status = 1'b1;
         advance    = 1'b0;
      end else if (item.mode == rv32ie_pkg::MODE_INSTR &&
                   state.waiting_kind == rv32ie_pkg::WAIT_NONE) begin
         case (item.opcode)
            rv32ie_pkg::OP_ADD:   begin wv = src_b + src_x;              wr = 1'b1; end
            rv32ie_pkg::OP_AND:   begin wv = src_b & src_x;              wr = 1'b1; end
            rv32ie_pkg::OP_OR:    begin wv = src_b | src_x;              wr = 1'b1; end
            rv32ie_pkg::OP_XOR:   begin wv = src_b ^ src_x;              wr = 1'b1; end
            rv32ie_pkg::OP_SUB:   begin wv = src_b - src_x;              wr = 1'b1; end
            rv32ie_pkg::OP_SLL:   begin wv = src_b << src_x[4:0];        wr = 1'b1; end
            rv32ie_pkg::OP_SRL:   begin wv = src_b >> src_x[4:0];        wr = 1'b1; end
            rv32ie_pkg::OP_SRA:   begin
               wv = 32'($signed(src_b) >>> src_x[4:0]);
               wr = 1'b1;
            end
            rv32ie_pkg::OP_SLT:   begin
               wv = {31'd0, $signed(src_b) < $signed(src_x)};
               wr = 1'b1;
            end
            rv32ie_pkg::OP_SLTU:  begin wv = {31'd0, src_b < src_x};     wr = 1'b1; end
            rv32ie_pkg::OP_ADDI:  begin wv = src_b + item.imm;           wr = 1'b1; end
            rv32ie_pkg::OP_ANDI:  begin wv = src_b & item.imm;           wr = 1'b1; end
            rv32ie_pkg::OP_ORI:   begin wv = src_b | item.imm;           wr = 1'b1; end
            rv32ie_pkg::OP_XORI:  begin wv = src_b ^ item.imm;           wr = 1'b1; end
            rv32ie_pkg::OP_SLLI:  begin wv = src_b << item.imm[4:0];     wr = 1'b1; end
            rv32ie_pkg::OP_SRLI:  begin wv = src_b >> item.imm[4:0];     wr = 1'b1; end
            rv32ie_pkg::OP_SRAI:  begin
               wv = 32'($signed(src_b) >>> item.imm[4:0]);
               wr = 1'b1;
            end
            rv32ie_pkg::OP_SLTI:  begin
               wv = {31'd0, $signed(src_b) < $signed(item.imm)};
               wr = 1'b1;
            end
            rv32ie_pkg::OP_SLTIU: begin wv = {31'd0, src_b < item.imm};  wr = 1'b1; end
            rv32ie_pkg::OP_LB, rv32ie_pkg::OP_LBU, rv32ie_pkg::OP_LH,
            rv32ie_pkg::OP_LHU, rv32ie_pkg::OP_LW: begin
               rsp.mem_request         = rv32ie_pkg::MEM_READ;
               rsp.mem_access_kind     = 3'(item.opcode - rv32ie_pkg::OP_LB);
               rsp.mem_address         = src_b + item.imm;
               state_next.pending_dest = item.reg_first;
               state_next.waiting_kind = rv32ie_pkg::WAIT_LOAD;
               advance                 = 1'b0;
            end
            rv32ie_pkg::OP_SB, rv32ie_pkg::OP_SH, rv32ie_pkg::OP_SW: begin
               rsp.mem_request         = rv32ie_pkg::MEM_WRITE;
               rsp.mem_access_kind     = 3'(item.opcode - rv32ie_pkg::OP_LB);
               rsp.mem_address         = src_b + item.imm;
               rsp.mem_write_data      = src_x;
               state_next.waiting_kind = rv32ie_pkg::WAIT_STORE;
               advance                 = 1'b0;
            end
            rv32ie_pkg::OP_BEQ:  if (src_x == src_b) npc32 = item.imm;
            rv32ie_pkg::OP_BNE:  if (src_x != src_b) npc32 = item.imm;
            rv32ie_pkg::OP_BGE:  if (!($signed(src_x) < $signed(src_b))) npc32 = item.imm;
            rv32ie_pkg::OP_BGEU: if (src_x >= src_b) npc32 = item.imm;
            rv32ie_pkg::OP_BLT:  if ($signed(src_x) < $signed(src_b)) npc32 = item.imm;
            rv32ie_pkg::OP_BLTU: if (src_x < src_b) npc32 = item.imm;
            rv32ie_pkg::OP_JAL: begin
               wv    = pc32 + rv32ie_pkg::PcStep;
               wr    = 1'b1;
               npc32 = item.imm;
            end
            rv32ie_pkg::OP_JALR: begin
               wv    = pc32 + rv32ie_pkg::PcStep;
               wr    = 1'b1;
               npc32 = src_b + item.imm;
            end
            rv32ie_pkg::OP_AUIPC: begin
               wv = pc32 + (item.imm << rv32ie_pkg::UpperShift);
               wr = 1'b1;
            end
            rv32ie_pkg::OP_LUI: begin
               wv = item.imm << rv32ie_pkg::UpperShift;
               wr = 1'b1;
            end
            default: begin
               // HCF, unimplemented and undefined codes stop the block
               state_next.halt = 1'b1;
               advance         = 1'b0;
            end
         endcase
      end else if (item.mode == rv32ie_pkg::MODE_LOAD &&
                   state.waiting_kind == rv32ie_pkg::WAIT_LOAD) begin
         widx                    = state.pending_dest;
         wv                      = item.load_data;
         wr                      = 1'b1;
         state_next.waiting_kind = rv32ie_pkg::WAIT_NONE;
      end else if (item.mode == rv32ie_pkg::MODE_STORE &&
                   state.waiting_kind == rv32ie_pkg::WAIT_STORE) begin
         state_next.waiting_kind = rv32ie_pkg::WAIT_NONE;
      end else begin
         rsp.status = 1'b1;
         advance    = 1'b0;
      end

      // drop writes to x0
      wr_eff        = wr && (widx != 5'd0);
      rsp.reg_write = wr_eff;
      rsp.reg_index = wr_eff ? widx : 5'd0;
      rsp.reg_value = wr_eff ? wv : 32'd0;

      if (advance) begin
         state_next.pc = rv32ie_pkg::wrap_pc(npc32);
      end
      rsp.next_pc = state_next.pc;
      rsp.halted  = state_next.halt;
   end

endmodule

`default_nettype wire

FILE: sv/rv32i_decoded_instruction_execute.sv
// Top level of the RV32I decoded-instruction execute block.
// Uses rv32ie_pkg, rv32ie_regfile, rv32ie_exec and the assertion macro header.
`default_nettype none

//  channel   dir  handshake              payload
//  req_*     in   req_valid/req_ready    mode, opcode, regs, imm, load_data
//  rsp_*     out  rsp_valid/rsp_ready    next_pc, mem request, reg write, status
//
//  One beat per cycle sustained while rsp_ready stays high. An accepted beat is
//  held in the operand stage (register-file read data registered there), then in
//  the result register that drives rsp_*. State commits as a beat leaves the
//  operand stage; a one-entry bypass covers the write made at the edge the next
//  beat was read. Reset clears the register file at once by its valid bits.
//  req_ready drops only when both stages hold beats and rsp_ready is low.

`include "rv32i_decoded_instruction_execute_macros.svh"

module rv32i_decoded_instruction_execute (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_mode,
   input  wire logic [5:0]         req_opcode,
   input  wire logic [4:0]         req_reg_first,
   input  wire logic [4:0]         req_reg_second,
   input  wire logic [4:0]         req_reg_third,
   input  wire logic signed [31:0] req_imm,
   input  wire logic [31:0]        req_load_data,

   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_next_pc,
   output logic [1:0]              rsp_mem_request,
   output logic [2:0]              rsp_mem_access_kind,
   output logic [31:0]             rsp_mem_address,
   output logic [31:0]             rsp_mem_write_data,
   output logic                    rsp_reg_write,
   output logic [4:0]              rsp_reg_index,
   output logic [31:0]             rsp_reg_value,
   output logic                    rsp_halted,
   output logic                    rsp_status
);

   // operand stage
   logic                  s1_valid_ff;
   rv32ie_pkg::item_type  s1_item_ff;
   rv32ie_pkg::item_type  req_item;
   logic                  s1_advance;
   logic                  req_fire;

   // architectural state other than the register file
   rv32ie_pkg::state_type state_ff;
   rv32ie_pkg::state_type state_in;

   // write seen at the edge the operand-stage beat was read
   logic                  byp_valid_ff;
   logic [4:0]            byp_idx_ff;
   logic [31:0]           byp_val_ff;

   // result register
   logic                  rsp_valid_ff;
   rv32ie_pkg::rsp_type   rsp_data_ff;
   rv32ie_pkg::rsp_type   exec_rsp;

   logic [31:0]           rf_data_a;
   logic [31:0]           rf_data_b;
   logic [4:0]            s1_addr_b;
   logic [31:0]           src_b;
   logic [31:0]           src_x;
   logic                  wr_en;

   assign req_item = '{mode:       req_mode,
                       opcode:     req_opcode,
                       reg_first:  req_reg_first,
                       reg_second: req_reg_second,
                       reg_third:  req_reg_third,
                       imm:        req_imm,
                       load_data:  req_load_data};

   // advance when the result register is free or being drained
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_fire   = req_valid && req_ready;
   assign wr_en      = s1_advance && exec_rsp.reg_write;

   rv32ie_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_addr_a (req_reg_second),
      .rd_addr_b (rv32ie_pkg::port_b_addr(req_opcode, req_reg_first, req_reg_third)),
      .rd_data_a (rf_data_a),
      .rd_data_b (rf_data_b),
      .wr_en     (wr_en),
      .wr_addr   (exec_rsp.reg_index),
      .wr_data   (exec_rsp.reg_value)
   );

   // forward the write that raced the read; x0 is never written so never matched
   assign s1_addr_b = rv32ie_pkg::port_b_addr(s1_item_ff.opcode, s1_item_ff.reg_first,
                                              s1_item_ff.reg_third);
   assign src_b = (byp_valid_ff && byp_idx_ff == s1_item_ff.reg_second) ? byp_val_ff
                                                                       : rf_data_a;
   assign src_x = (byp_valid_ff && byp_idx_ff == s1_addr_b) ? byp_val_ff : rf_data_b;

   rv32ie_exec u_exec (
      .item       (s1_item_ff),
      .src_b      (src_b),
      .src_x      (src_x),
      .state      (state_ff),
      .rsp        (exec_rsp),
      .state_next (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // payload: hold while stalled
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
   end

   // capture the write landing at the edge a new beat reads the register file
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         byp_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byp_idx_ff <= exec_rsp.reg_index;
         byp_val_ff <= exec_rsp.reg_value;
      end
   end

   // commit state as the beat leaves the operand stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{pc: 16'd0, pending_dest: 5'd0,
                       waiting_kind: rv32ie_pkg::WAIT_NONE, halt: 1'b0};
      end else if (s1_advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= exec_rsp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_pc         = rsp_data_ff.next_pc;
   assign rsp_mem_request     = rsp_data_ff.mem_request;
   assign rsp_mem_access_kind = rsp_data_ff.mem_access_kind;
   assign rsp_mem_address     = rsp_data_ff.mem_address;
   assign rsp_mem_write_data  = rsp_data_ff.mem_write_data;
   assign rsp_reg_write       = rsp_data_ff.reg_write;
   assign rsp_reg_index       = rsp_data_ff.reg_index;
   assign rsp_reg_value       = rsp_data_ff.reg_value;
   assign rsp_halted          = rsp_data_ff.halted;
   assign rsp_status          = rsp_data_ff.status;

   // halt holds until reset
   `RV32IE_ASSERT_NEXT(a_halt_sticky, clock, reset, state_ff.halt, state_ff.halt,
                       "halt cleared")
   // x0 is never written
   `RV32IE_ASSERT_SAME(a_no_x0_write, clock, reset, wr_en, exec_rsp.reg_index != 5'd0,
                       "x0 write")
   // an ignored beat never writes a register
   `RV32IE_ASSERT_SAME(a_ignored_no_write, clock, reset,
                       rsp_valid_ff && rsp_data_ff.status,
                       !rsp_data_ff.reg_write,
                       "ignored beat wrote")
   // a read request leaves the block waiting for load data
   `RV32IE_ASSERT_NEXT(a_read_waits, clock, reset,
                       s1_advance && exec_rsp.mem_request == rv32ie_pkg::MEM_READ,
                       state_ff.waiting_kind == rv32ie_pkg::WAIT_LOAD,
                       "no load wait")

endmodule

`default_nettype wire
